### rtl/ddf_pkg.sv
// Shared types and constants for the decimal digit formatter.
package ddf_pkg;

  // Field widths of the stream payloads
  localparam int VALUE_W        = 16;
  localparam int MIN_W          = 3;
  localparam int CHAR_W         = 6;

  // Decimal digits a VALUE_W-bit value can need, and the BCD register width
  localparam int VALUE_DIGITS   = 5;
  localparam int BCD_W          = 4 * VALUE_DIGITS;

  // Default upper bound on the padded width
  localparam int DEF_MAX_DIGITS = 5;

  // Conversion step counter, one step per input bit
  localparam int CONV_CNT_W     = $clog2(VALUE_W);

  // ASCII codes of the digit characters
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'h30;
  localparam logic [CHAR_W-1:0] ASCII_NINE = 6'h39;

  // Stream data widths, rounded up to whole bytes
  localparam int S_DATA_W = ((VALUE_W + MIN_W + 7) / 8) * 8;
  localparam int M_DATA_W = ((CHAR_W + 7) / 8) * 8;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;   // capture a new number and clear the BCD register
    logic shift;  // one shift-add-3 conversion step
    logic prep;   // set the character position from the digit count
    logic emit;   // load the next character into the output register
  } ddf_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic pos_zero;  // the current character is the last one
    logic out_free;  // the output register can take a character this cycle
  } ddf_status_t;

endpackage

### rtl/decimal_digit_formatter_top.sv
// Top level of the decimal digit formatter: stream ports, controller and datapath.
//
// Each transaction on the slave side carries a 16-bit unsigned number and a
// minimum digit count; the block answers with that number's decimal digits as
// ASCII characters, most significant first, one transaction per character,
// with tlast on the final one. Leading '0' characters pad the output to the
// minimum count (0 counts as 1, counts above MAX_DIGITS are cut to MAX_DIGITS),
// and a number with more digits than the minimum is printed in full. The block
// accepts the number, runs the bit-serial shift-add-3 BCD conversion (one input
// bit a cycle), sets up the digit position, then loads the characters one at a
// time into the output register, waiting while that register is still occupied.
// The next number is accepted as soon as the last character sits in the output
// register.
module decimal_digit_formatter_top
  import ddf_pkg::*;
#(
  parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [S_DATA_W-1:0] s_axis_tdata,   // [15:0] value, [18:16] min_digits
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [M_DATA_W-1:0] m_axis_tdata,   // [5:0] char_code
  output logic                m_axis_tlast    // last_char
);

  ddf_cmd_t          cmd;
  ddf_status_t       status;
  logic [CHAR_W-1:0] char_code;

  ddf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ddf_datapath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .value      (s_axis_tdata[VALUE_W-1:0]),
    .min_digits (s_axis_tdata[VALUE_W +: MIN_W]),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_char   (char_code),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {{(M_DATA_W - CHAR_W){1'b0}}, char_code};

endmodule

### rtl/ddf_ctrl.sv
// Controller state machine of the decimal digit formatter.
module ddf_ctrl
  import ddf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  ddf_status_t status,
  output ddf_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_PREP = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  localparam logic [CONV_CNT_W-1:0] CONV_LAST = CONV_CNT_W'(VALUE_W - 1);

  state_t                state;
  state_t                state_next;
  logic [CONV_CNT_W-1:0] cnt;

  assign in_ready = (state == ST_IDLE);

  // Decode the next state and the datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.shift = 1'b1;
        if (cnt == CONV_LAST) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.pos_zero) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold the state and the conversion step count
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CONV) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
    end
  end

  a_conv_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONV && cnt == CONV_LAST) |=> state == ST_PREP)
    else $error("conversion did not end after the last step");

  a_prep_once: assert property (@(posedge clk) disable iff (rst)
    state == ST_PREP |=> state == ST_EMIT)
    else $error("position setup did not lead to emission");

  a_emit_end: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && status.pos_zero) |=> state == ST_IDLE)
    else $error("controller kept emitting after the last character");

endmodule

### rtl/ddf_datapath.sv
// Datapath of the decimal digit formatter: BCD conversion and character output.
module ddf_datapath
  import ddf_pkg::*;
#(
  parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
  input  logic               clk,
  input  logic               rst,
  input  ddf_cmd_t           cmd,
  output ddf_status_t        status,
  input  logic [VALUE_W-1:0] value,
  input  logic [MIN_W-1:0]   min_digits,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CHAR_W-1:0]  out_char,
  output logic               out_last
);

  localparam int MAX_OUT   = (MAX_DIGITS > VALUE_DIGITS) ? MAX_DIGITS : VALUE_DIGITS;
  localparam int CNT_W     = $clog2(MAX_OUT + 1);
  localparam int POS_W     = $clog2(MAX_OUT);
  localparam int DIG_IDX_W = $clog2(VALUE_DIGITS);
  localparam logic [CNT_W-1:0] MAXD_C = CNT_W'(MAX_DIGITS);
  localparam logic [CNT_W-1:0] ONE_C  = CNT_W'(1);

  logic [VALUE_W-1:0] bin;
  logic [BCD_W-1:0]   bcd;
  logic [BCD_W-1:0]   bcd_adj;
  logic [MIN_W-1:0]   want;
  logic [POS_W-1:0]   pos;
  logic [3:0]         dig [VALUE_DIGITS];
  logic [3:0]         dig_sel;
  logic [CNT_W-1:0]   want_c;
  logic [CNT_W-1:0]   n_dig;
  logic [CNT_W-1:0]   total;
  logic [CNT_W-1:0]   total_m1;

  // Split the BCD register into digits and add 3 to each digit of five or more
  always_comb begin
    for (int i = 0; i < VALUE_DIGITS; i++) begin
      dig[i] = bcd[4*i +: 4];
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? (bcd[4*i +: 4] + 4'd3) : bcd[4*i +: 4];
    end
  end

  // Count the significant digits; zero still has one
  always_comb begin
    n_dig = ONE_C;
    for (int i = 1; i < VALUE_DIGITS; i++) begin
      if (dig[i] != 4'd0) begin
        n_dig = CNT_W'(i + 1);
      end
    end
  end

  // Clamp the requested width and take the longer of the two
  always_comb begin
    if (want == '0) begin
      want_c = ONE_C;
    end else if (CNT_W'(want) > MAXD_C) begin
      want_c = MAXD_C;
    end else begin
      want_c = CNT_W'(want);
    end
    total    = (n_dig > want_c) ? n_dig : want_c;
    total_m1 = total - ONE_C;
  end

  // Padding positions above the stored digits read as zero
  assign dig_sel = (32'(pos) < VALUE_DIGITS) ? dig[pos[DIG_IDX_W-1:0]] : 4'd0;

  assign status.pos_zero = (pos == '0);
  assign status.out_free = !out_valid || out_ready;

  // Load, convert one bit a step, and walk the character position down
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin  <= value;
      bcd  <= '0;
      want <= min_digits;
    end else if (cmd.shift) begin
      bcd <= {bcd_adj[BCD_W-2:0], bin[VALUE_W-1]};
      bin <= {bin[VALUE_W-2:0], 1'b0};
    end
    if (cmd.prep) begin
      pos <= total_m1[POS_W-1:0];
    end else if (cmd.emit) begin
      pos <= pos - 1'b1;
    end
  end

  // Output register: fill on emit, drop once the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_char <= ASCII_ZERO + {2'b00, dig_sel};
      out_last <= (pos == '0);
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free)
    else $error("character emitted into an occupied output register");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_last == $past(pos == '0))
    else $error("last flag does not match the character position");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_char >= ASCII_ZERO && out_char <= ASCII_NINE))
    else $error("output character is not a decimal digit");

endmodule

### verif/decimal_digit_formatter_checker.sv
// Checker for the decimal digit formatter: predicts the ASCII characters and compares them.
`timescale 1ns / 100ps

module decimal_digit_formatter_checker
  import ddf_pkg::*;
#(
  parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [S_DATA_W-1:0] s_axis_tdata,   // [15:0] value, [18:16] min_digits
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [M_DATA_W-1:0] m_axis_tdata,   // [5:0] char_code
  input  logic                m_axis_tlast,   // last_char
  output int                  fail_count,
  output int                  chars_pending,
  output int                  chars_checked
);

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } digit_char_t;

  digit_char_t expected_chars[$];
  int          mismatches = 0;
  int          checked    = 0;
  int          pending    = 0;

  assign fail_count    = mismatches;
  assign chars_checked = checked;
  assign chars_pending = pending;

  // Work out the characters one number should print, most significant first
  function automatic void queue_expected_digits(input logic [VALUE_W-1:0] number,
                                                input logic [MIN_W-1:0]   width_req);
    logic [3:0]  digit [0:7];
    int unsigned rest;
    int unsigned ndig;
    int unsigned width;
    int unsigned total;
    int unsigned pad;
    digit_char_t c;
    rest = 32'(number);
    ndig = 0;
    // Peel off digits, least significant first; zero still gives one digit
    do begin
      digit[3'(ndig)] = 4'(rest % 10);
      rest            = rest / 10;
      ndig++;
    end while (rest != 0);
    // Clamp the requested width to 1..MAX_DIGITS
    width = 32'(width_req);
    if (width == 0) width = 1;
    if (width > MAX_DIGITS) width = MAX_DIGITS;
    total = (ndig > width) ? ndig : width;
    pad   = total - ndig;
    for (int unsigned k = 0; k < total; k++) begin
      if (k < pad) c.code = ASCII_ZERO;
      else c.code = ASCII_ZERO + CHAR_W'(digit[3'(ndig - 1 - (k - pad))]);
      c.last = (k + 1 == total);
      expected_chars.push_back(c);
    end
  endfunction

  // Predict on each input transaction, compare on each output transaction
  always @(posedge clk) begin
    digit_char_t want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        queue_expected_digits(s_axis_tdata[VALUE_W-1:0],
                              s_axis_tdata[VALUE_W+MIN_W-1:VALUE_W]);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected character: char_code %0h last_char %0b",
                 m_axis_tdata[CHAR_W-1:0], m_axis_tlast);
          mismatches++;
        end else begin
          want = expected_chars.pop_front();
          checked++;
          if (m_axis_tdata[CHAR_W-1:0] !== want.code) begin
            $error("char_code: expected %0h, actual %0h", want.code,
                   m_axis_tdata[CHAR_W-1:0]);
            mismatches++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last_char: expected %0b, actual %0b", want.last, m_axis_tlast);
            mismatches++;
          end
        end
      end
      pending = expected_chars.size();
    end
  end

endmodule

### verif/tb_decimal_digit_formatter_top.sv
// Testbench top for the decimal digit formatter: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_decimal_digit_formatter_top;
  import ddf_pkg::*;

  localparam int MAX_DIGITS    = DEF_MAX_DIGITS;
  localparam int RAND_PER_PASS = 80;
  localparam int QUIET_LIMIT   = 5000;
  localparam int TAIL_CYCLES   = 50;

  logic                clk;
  logic                rst           = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic                m_axis_tlast;

  int fail_count;
  int chars_pending;
  int chars_checked;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int numbers_sent   = 0;
  int quiet_cycles   = 0;

  decimal_digit_formatter_top #(
    .MAX_DIGITS(MAX_DIGITS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  decimal_digit_formatter_checker #(
    .MAX_DIGITS(MAX_DIGITS)
  ) i_checker (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .fail_count   (fail_count),
    .chars_pending(chars_pending),
    .chars_checked(chars_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Stall the character output at random
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Abort when nothing moves on either side for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Offer one number after a random gap and hold it until accepted; returns at a falling edge
  task automatic send_number(input logic [VALUE_W-1:0] value, input logic [MIN_W-1:0] min_digits);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(S_DATA_W - VALUE_W - MIN_W){1'b0}}, min_digits, value};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    numbers_sent++;
    @(negedge clk);
  endtask

  // Drop valid and hold off until every predicted character has come out
  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (chars_pending != 0) @(negedge clk);
  endtask

  initial begin
    logic [VALUE_W-1:0] value;
    logic [MIN_W-1:0]   min_digits;
    int                 digit_class;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: zero, digit-count boundaries, full scale, clamped widths, alternating bits
    send_number(16'd0, 3'd1);
    send_number(16'd0, 3'd5);
    send_number(16'd0, 3'd0);
    send_number(16'd0, 3'd7);
    send_number(16'd65535, 3'd1);
    send_number(16'd65535, 3'd5);
    send_number(16'd65535, 3'd7);
    send_number(16'd9, 3'd2);
    send_number(16'd10, 3'd1);
    send_number(16'd99, 3'd3);
    send_number(16'd100, 3'd2);
    send_number(16'd999, 3'd4);
    send_number(16'd1000, 3'd5);
    send_number(16'd9999, 3'd6);
    send_number(16'd10000, 3'd3);
    send_number(16'd12345, 3'd3);
    send_number(16'd7, 3'd6);
    send_number(16'd42, 3'd0);
    send_number(16'hAAAA, 3'd4);
    send_number(16'h5555, 3'd2);
    send_number(16'd1, 3'd4);
    send_number(16'd300, 3'd1);
    wait_for_drain();

    // Random numbers under four handshake regimes, draining between them
    for (int pass = 0; pass < 4; pass++) begin
      case (pass)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 81;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 81;
        end
        default: begin
          send_idle_pct  = 14;
          recv_stall_pct = 14;
        end
      endcase
      for (int i = 0; i < RAND_PER_PASS; i++) begin
        // Spread values over every digit count
        digit_class = $urandom_range(0, 5);
        case (digit_class)
          0: value = VALUE_W'($urandom_range(0, 9));
          1: value = VALUE_W'($urandom_range(10, 99));
          2: value = VALUE_W'($urandom_range(100, 999));
          3: value = VALUE_W'($urandom_range(1000, 9999));
          4: value = VALUE_W'($urandom_range(10000, 65535));
          default: value = VALUE_W'($urandom);
        endcase
        if ($urandom_range(0, 4) == 0) min_digits = MIN_W'($urandom_range(0, 7));
        else min_digits = MIN_W'($urandom_range(1, 5));
        send_number(value, min_digits);
      end
      wait_for_drain();
    end

    // Let any stray character show up
    recv_stall_pct = 0;
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Sent %0d numbers (directed plus four handshake regimes), checked %0d characters.",
             numbers_sent, chars_checked);
    $display("Values spanned every digit count and min_digits every code from 0 to 7.");
    if (fail_count == 0 && chars_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
